// ===== design/smas_pkg.sv =====
// Shared types and constants for the sprite motion and animation step block.
// Item structs, microcode control word, datapath status and register indexes.
// No dependencies.
package smas_pkg;

  localparam int FRAME_W    = 16;
  localparam int PHASE_W    = 8;
  localparam int SUB_W      = 8;
  localparam int LIM_W      = 15;
  localparam int CNT_W      = 8;
  localparam int PC_W       = 4;
  localparam int ITER_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic               func;
    logic signed [15:0] new_pos_x;
    logic signed [15:0] new_pos_y;
    logic signed [15:0] new_frame;
    logic signed [15:0] new_accel_x;
    logic signed [15:0] new_accel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] frame_index;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_FETCH,
    OP_LOAD,
    OP_PHASE,
    OP_DIVSTEP,
    OP_MODFIX,
    OP_GRAV,
    OP_CLAMP,
    OP_FRIC,
    OP_MOVE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_LOAD,
    C_NOCOUNT,
    C_LOOP
  } cond_t;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } axis_t;

  typedef struct packed {
    op_t             op;
    axis_t           axis;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic is_load;
    logic count_zero;
    logic iter_done;
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANIM_SPEED,
    REG_FRAME_COUNT,
    REG_X_GRAVITY,
    REG_Y_GRAVITY,
    REG_X_LIMIT,
    REG_Y_LIMIT,
    REG_X_FRICTION,
    REG_Y_FRICTION
  } reg_idx_t;

endpackage

// ===== design/smas_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on smas_pkg for the control word and status types.
module smas_seq
  import smas_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_free,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam logic [PC_W-1:0] PC_FETCH   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV     = PC_W'(2);
  localparam logic [PC_W-1:0] PC_AXIS_X  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_LOAD    = PC_W'(12);
  localparam logic [PC_W-1:0] PC_EMIT    = PC_W'(13);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            hold;
  logic            take;

  // control store
  always_comb begin
    unique case (pc)
      4'd0:    ctl = '{OP_FETCH,   AXIS_X, C_LOAD,    PC_LOAD};
      4'd1:    ctl = '{OP_PHASE,   AXIS_X, C_NOCOUNT, PC_AXIS_X};
      4'd2:    ctl = '{OP_DIVSTEP, AXIS_X, C_LOOP,    PC_DIV};
      4'd3:    ctl = '{OP_MODFIX,  AXIS_X, C_NEXT,    PC_FETCH};
      4'd4:    ctl = '{OP_GRAV,    AXIS_X, C_NEXT,    PC_FETCH};
      4'd5:    ctl = '{OP_CLAMP,   AXIS_X, C_NEXT,    PC_FETCH};
      4'd6:    ctl = '{OP_FRIC,    AXIS_X, C_NEXT,    PC_FETCH};
      4'd7:    ctl = '{OP_MOVE,    AXIS_X, C_NEXT,    PC_FETCH};
      4'd8:    ctl = '{OP_GRAV,    AXIS_Y, C_NEXT,    PC_FETCH};
      4'd9:    ctl = '{OP_CLAMP,   AXIS_Y, C_NEXT,    PC_FETCH};
      4'd10:   ctl = '{OP_FRIC,    AXIS_Y, C_NEXT,    PC_FETCH};
      4'd11:   ctl = '{OP_MOVE,    AXIS_Y, C_JUMP,    PC_EMIT};
      4'd12:   ctl = '{OP_LOAD,    AXIS_X, C_NEXT,    PC_FETCH};
      default: ctl = '{OP_EMIT,    AXIS_X, C_JUMP,    PC_FETCH};
    endcase
  end

  // wait for an input beat at fetch and for a free output slot at emit
  assign hold = ((ctl.op == OP_FETCH) && !in_valid) || ((ctl.op == OP_EMIT) && !out_free);

  always_comb begin
    unique case (ctl.cond)
      C_JUMP:    take = 1'b1;
      C_LOAD:    take = stat.is_load;
      C_NOCOUNT: take = stat.count_zero;
      C_LOOP:    take = !stat.iter_done;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef ASSERT_OFF
  a_loop_stays: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_DIVSTEP) && !stat.iter_done |=> (ctl.op == OP_DIVSTEP))
    else $error("divide loop left early");
`endif

endmodule

// ===== design/smas_dp.sv =====
// Datapath: configuration registers, sprite state, work registers and the
// shift-subtract remainder unit, all driven by the microcode control word.
// Depends on smas_pkg.
module smas_dp
  import smas_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  logic                  accept,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output stat_t                 stat,
  output out_item_t             result
);

  // configuration
  logic [15:0]      anim_speed;
  logic [CNT_W-1:0] frame_count;
  logic [15:0]      x_gravity;
  logic [15:0]      y_gravity;
  logic [LIM_W-1:0] x_limit;
  logic [LIM_W-1:0] y_limit;
  logic [LIM_W-1:0] x_friction;
  logic [LIM_W-1:0] y_friction;

  // sprite state
  logic [COORD_WIDTH-1:0] position_x;
  logic [COORD_WIDTH-1:0] position_y;
  logic [FRAME_W-1:0]     frame;
  logic [PHASE_W-1:0]     phase;
  logic [15:0]            accel_x;
  logic [15:0]            accel_y;
  logic [SUB_W-1:0]       sub_x;
  logic [SUB_W-1:0]       sub_y;

  // work registers
  in_item_t          item;
  logic [15:0]       tmp;
  logic [FRAME_W-1:0] mag;
  logic [CNT_W-1:0]  rem;
  logic              neg;
  logic [ITER_W-1:0] iter;

  logic [15:0]            grav_sel;
  logic [LIM_W-1:0]       lim_sel;
  logic [LIM_W-1:0]       fric_sel;
  logic [15:0]            accel_sel;
  logic [SUB_W-1:0]       sub_sel;
  logic [COORD_WIDTH-1:0] pos_sel;

  logic [15:0]          phase_sum;
  logic signed [7:0]    phase_carry;
  logic [FRAME_W-1:0]   frame_diff;
  logic [CNT_W:0]       rem_shift;
  logic [CNT_W:0]       rem_sub;
  logic [CNT_W-1:0]     rem_step;
  logic [CNT_W-1:0]     rem_fixed;
  logic signed [16:0]   n17;
  logic signed [16:0]   lim17;
  logic signed [16:0]   fric17;
  logic signed [16:0]   fric_pos;
  logic signed [16:0]   fric_neg;
  logic [15:0]          clamped;
  logic [15:0]          rubbed;
  logic [15:0]          move_sum;
  logic signed [7:0]    move_carry;
  logic [COORD_WIDTH-1:0] pos_moved;

  assign grav_sel  = (ctl.axis == AXIS_Y) ? y_gravity  : x_gravity;
  assign lim_sel   = (ctl.axis == AXIS_Y) ? y_limit    : x_limit;
  assign fric_sel  = (ctl.axis == AXIS_Y) ? y_friction : x_friction;
  assign accel_sel = (ctl.axis == AXIS_Y) ? accel_y    : accel_x;
  assign sub_sel   = (ctl.axis == AXIS_Y) ? sub_y      : sub_x;
  assign pos_sel   = (ctl.axis == AXIS_Y) ? position_y : position_x;

  // animation phase and frame step
  assign phase_sum   = {8'h00, phase} + anim_speed;
  assign phase_carry = signed'(phase_sum[15:8]);
  assign frame_diff  = frame - FRAME_W'(phase_carry);

  // one remainder bit per step
  assign rem_shift = {rem, mag[FRAME_W-1]};
  assign rem_sub   = rem_shift - {1'b0, frame_count};
  assign rem_step  = (rem_shift >= {1'b0, frame_count}) ? rem_sub[CNT_W-1:0]
                                                         : rem_shift[CNT_W-1:0];
  assign rem_fixed = (neg && (rem != '0)) ? (frame_count - rem) : rem;

  // clamp and friction on the working acceleration
  assign n17    = 17'(signed'(tmp));
  assign lim17  = signed'({2'b00, lim_sel});
  assign fric17 = signed'({2'b00, fric_sel});

  always_comb begin
    priority if (lim_sel == '0) begin
      clamped = tmp;
    end else if (n17 > lim17) begin
      clamped = lim17[15:0];
    end else if (n17 < -lim17) begin
      clamped = 16'(-lim17);
    end else begin
      clamped = tmp;
    end
  end

  assign fric_pos = n17 - fric17;
  assign fric_neg = n17 + fric17;

  always_comb begin
    priority if (n17 < 0) begin
      rubbed = (fric_neg > 0) ? 16'h0000 : fric_neg[15:0];
    end else if (n17 > 0) begin
      rubbed = (fric_pos < 0) ? 16'h0000 : fric_pos[15:0];
    end else begin
      rubbed = tmp;
    end
  end

  // sub-pixel accumulate and whole-pixel move
  assign move_sum   = {8'h00, sub_sel} + accel_sel;
  assign move_carry = signed'(move_sum[15:8]);
  assign pos_moved  = pos_sel + COORD_WIDTH'(move_carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_speed  <= '0;
      frame_count <= CNT_W'(1);
      x_gravity   <= '0;
      y_gravity   <= '0;
      x_limit     <= '0;
      y_limit     <= '0;
      x_friction  <= '0;
      y_friction  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ANIM_SPEED:  anim_speed  <= cfg_data;
        REG_FRAME_COUNT: frame_count <= cfg_data[CNT_W-1:0];
        REG_X_GRAVITY:   x_gravity   <= cfg_data;
        REG_Y_GRAVITY:   y_gravity   <= cfg_data;
        REG_X_LIMIT:     x_limit     <= cfg_data[LIM_W-1:0];
        REG_Y_LIMIT:     y_limit     <= cfg_data[LIM_W-1:0];
        REG_X_FRICTION:  x_friction  <= cfg_data[LIM_W-1:0];
        REG_Y_FRICTION:  y_friction  <= cfg_data[LIM_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x <= '0;
      position_y <= '0;
      frame      <= '0;
      phase      <= '0;
      accel_x    <= '0;
      accel_y    <= '0;
      sub_x      <= '0;
      sub_y      <= '0;
      iter       <= '0;
    end else begin
      unique case (ctl.op)
        OP_LOAD: begin
          position_x <= COORD_WIDTH'(item.new_pos_x);
          position_y <= COORD_WIDTH'(item.new_pos_y);
          frame      <= item.new_frame;
          accel_x    <= item.new_accel_x;
          accel_y    <= item.new_accel_y;
          sub_x      <= '0;
          sub_y      <= '0;
        end
        OP_PHASE: begin
          phase <= phase_sum[PHASE_W-1:0];
          frame <= frame_diff;
          iter  <= '0;
        end
        OP_DIVSTEP: begin
          iter <= iter + ITER_W'(1);
        end
        OP_MODFIX: begin
          frame <= FRAME_W'(rem_fixed);
        end
        OP_FRIC: begin
          if (ctl.axis == AXIS_Y) begin
            accel_y <= rubbed;
          end else begin
            accel_x <= rubbed;
          end
        end
        OP_MOVE: begin
          if (ctl.axis == AXIS_Y) begin
            sub_y      <= move_sum[SUB_W-1:0];
            position_y <= pos_moved;
          end else begin
            sub_x      <= move_sum[SUB_W-1:0];
            position_x <= pos_moved;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    unique case (ctl.op)
      OP_PHASE: begin
        neg <= frame_diff[FRAME_W-1];
        mag <= frame_diff[FRAME_W-1] ? (FRAME_W'(0) - frame_diff) : frame_diff;
        rem <= '0;
      end
      OP_DIVSTEP: begin
        rem <= rem_step;
        mag <= {mag[FRAME_W-2:0], 1'b0};
      end
      OP_GRAV:  tmp <= accel_sel + grav_sel;
      OP_CLAMP: tmp <= clamped;
      default: begin
      end
    endcase
  end

  assign stat.is_load    = in_data.func;
  assign stat.count_zero = (frame_count == '0);
  assign stat.iter_done  = (iter == ITER_W'(FRAME_W - 1));

  assign result.pos_x       = position_x[15:0];
  assign result.pos_y       = position_y[15:0];
  assign result.frame_index = frame;
  assign result.accel_x     = accel_x;
  assign result.accel_y     = accel_y;

`ifndef ASSERT_OFF
  a_frame_wrapped: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_MODFIX) |=> (frame < FRAME_W'(frame_count)))
    else $error("frame not reduced below count");
  a_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_CLAMP) && (lim_sel != '0) |=>
      (17'(signed'(tmp)) <= signed'({2'b00, $past(lim_sel)})) &&
      (17'(signed'(tmp)) >= -signed'({2'b00, $past(lim_sel)})))
    else $error("acceleration outside clamp");
`endif

endmodule

// ===== design/sprite_motion_animation_step.sv =====
// Sprite motion and animation step. A load item runs fetch, load and emit; a tick
// runs the phase step, the 16-step shift-subtract remainder loop and its fix (both
// skipped at frame count zero), then gravity, clamp, friction and move per axis, then emit.
// One item is in flight at a time; the next is accepted once the result is
// registered, even while it waits to be taken.
// Synchronous active-high reset: state zero, frame count one, output empty.
module sprite_motion_animation_step
  import smas_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_t      ctl;
  stat_t     stat;
  out_item_t result;
  logic      accept;
  logic      out_free;
  logic      emit;

  assign in_stall  = (ctl.op != OP_FETCH);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit      = (ctl.op == OP_EMIT) && out_free;
  assign cfg_ready = 1'b1;

  smas_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl)
  );

  smas_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second beat accepted while busy");
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    emit |=> !in_stall && out_valid)
    else $error("sequencer did not return to fetch after emit");
`endif

endmodule

// ===== tb/tb_sprite_motion_animation_step.sv =====
// Self-checking testbench for sprite_motion_animation_step: directed corner cases, then
// random phases of load and tick beats under random configuration, valid gaps and stalls.
// Depends on smas_pkg and the block itself.
module tb_sprite_motion_animation_step;
  import smas_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit idle_on = 1'b1;

  class motion_scoreboard;
    logic [15:0] anim_speed, x_gravity, y_gravity;
    logic [7:0]  frame_count;
    logic [14:0] x_limit, y_limit, x_friction, y_friction;

    logic [15:0] pos_x, pos_y, frame, accel_x, accel_y;
    logic [7:0]  phase, sub_x, sub_y;

    out_item_t   expected_q[$];
    int          errors;

    function new();
      anim_speed  = '0;
      frame_count = 8'd1;
      x_gravity   = '0;
      y_gravity   = '0;
      x_limit     = '0;
      y_limit     = '0;
      x_friction  = '0;
      y_friction  = '0;
      pos_x       = '0;
      pos_y       = '0;
      frame       = '0;
      accel_x     = '0;
      accel_y     = '0;
      phase       = '0;
      sub_x       = '0;
      sub_y       = '0;
      errors      = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] value);
      case (idx)
        REG_ANIM_SPEED:  anim_speed  = value;
        REG_FRAME_COUNT: frame_count = value[7:0];
        REG_X_GRAVITY:   x_gravity   = value;
        REG_Y_GRAVITY:   y_gravity   = value;
        REG_X_LIMIT:     x_limit     = value[14:0];
        REG_Y_LIMIT:     y_limit     = value[14:0];
        REG_X_FRICTION:  x_friction  = value[14:0];
        REG_Y_FRICTION:  y_friction  = value[14:0];
        default: ;
      endcase
    endfunction

    // 8.8 accumulate: keep the low byte, return the high byte as the signed carry
    function logic [7:0] carry_add(inout logic [7:0] acc, input logic [15:0] addend);
      logic [15:0] sum;
      sum = {8'h00, acc} + addend;
      acc = sum[7:0];
      return sum[15:8];
    endfunction

    function logic [15:0] next_accel(logic [15:0] a, logic [15:0] g,
                                     logic [14:0] lim, logic [14:0] fric);
      logic signed [15:0] s;
      int n, l, f;
      s = a + g;
      n = int'(s);
      l = int'(lim);
      f = int'(fric);
      if (l != 0) begin
        if (n > l) n = l;
        else if (n < -l) n = -l;
      end
      // step toward zero, never past it
      if (f != 0) begin
        if (n < 0) begin
          n += f;
          if (n > 0) n = 0;
        end else if (n > 0) begin
          n -= f;
          if (n < 0) n = 0;
        end
      end
      return n[15:0];
    endfunction

    function void note_input(in_item_t it);
      logic [7:0]         c;
      logic signed [15:0] d;
      int                 n, cnt;
      out_item_t          res;
      if (it.func) begin
        pos_x   = it.new_pos_x;
        pos_y   = it.new_pos_y;
        frame   = it.new_frame;
        accel_x = it.new_accel_x;
        accel_y = it.new_accel_y;
        sub_x   = '0;
        sub_y   = '0;
      end else begin
        c   = carry_add(phase, anim_speed);
        d   = frame - {{8{c[7]}}, c};
        n   = int'(d);
        cnt = int'(frame_count);
        if (cnt != 0) begin
          n = n % cnt;
          if (n < 0) n += cnt;
        end
        frame   = n[15:0];
        accel_x = next_accel(accel_x, x_gravity, x_limit, x_friction);
        accel_y = next_accel(accel_y, y_gravity, y_limit, y_friction);
        c       = carry_add(sub_x, accel_x);
        pos_x   = pos_x + {{8{c[7]}}, c};
        c       = carry_add(sub_y, accel_y);
        pos_y   = pos_y + {{8{c[7]}}, c};
      end
      res.pos_x       = pos_x;
      res.pos_y       = pos_y;
      res.frame_index = frame;
      res.accel_x     = accel_x;
      res.accel_y     = accel_y;
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      check_field("pos_x", got.pos_x, want.pos_x);
      check_field("pos_y", got.pos_y, want.pos_y);
      check_field("frame_index", got.frame_index, want.frame_index);
      check_field("accel_x", got.accel_x, want.accel_x);
      check_field("accel_y", got.accel_y, want.accel_y);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  motion_scoreboard sb;

  sprite_motion_animation_step DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // sample every handshake on the edge, before the block's own updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
    end
  end

  // receiver back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function logic [15:0] pick16();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      4: v = 16'($urandom_range(0, 255) - 128);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // 15-bit register value; bit 15 of the beat is random and must be dropped
  function logic [15:0] pick15(int small_max);
    logic [14:0] v;
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = 15'h7FFF;
      2, 3: v = 15'($urandom_range(1, small_max));
      default: v = 15'($urandom);
    endcase
    return {1'($urandom), v};
  endfunction

  function in_item_t tick_item();
    in_item_t it;
    it.func        = 1'b0;
    it.new_pos_x   = pick16();
    it.new_pos_y   = pick16();
    it.new_frame   = pick16();
    it.new_accel_x = pick16();
    it.new_accel_y = pick16();
    return it;
  endfunction

  function in_item_t load_item(logic [15:0] px, logic [15:0] py, logic [15:0] fr,
                               logic [15:0] ax, logic [15:0] ay);
    in_item_t it;
    it.func        = 1'b1;
    it.new_pos_x   = px;
    it.new_pos_y   = py;
    it.new_frame   = fr;
    it.new_accel_x = ax;
    it.new_accel_y = ay;
    return it;
  endfunction

  function in_item_t random_item();
    in_item_t it;
    it.func        = ($urandom_range(0, 5) == 0);
    it.new_pos_x   = pick16();
    it.new_pos_y   = pick16();
    it.new_frame   = pick16();
    it.new_accel_x = pick16();
    it.new_accel_y = pick16();
    return it;
  endfunction

  task send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // drop valid, then hold until every expected result has been taken
  task finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task write_register(reg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task apply_settings(logic [15:0] speed, logic [15:0] count,
                      logic [15:0] xg, logic [15:0] yg, logic [15:0] xl,
                      logic [15:0] yl, logic [15:0] xf, logic [15:0] yf);
    write_register(REG_ANIM_SPEED, speed);
    write_register(REG_FRAME_COUNT, count);
    write_register(REG_X_GRAVITY, xg);
    write_register(REG_Y_GRAVITY, yg);
    write_register(REG_X_LIMIT, xl);
    write_register(REG_Y_LIMIT, yl);
    write_register(REG_X_FRICTION, xf);
    write_register(REG_Y_FRICTION, yf);
    cfg_valid <= 1'b0;
  endtask

  task run_random_phase(int n_items);
    logic [15:0] speed, count, xg, yg;
    logic [7:0]  cnt;
    case ($urandom_range(0, 4))
      0: speed = 16'h7FFF;
      1: speed = 16'h8000;
      2: speed = 16'($urandom_range(0, 1023) - 512);
      default: speed = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: cnt = 8'd0;
      1: cnt = 8'd1;
      2: cnt = 8'd255;
      3, 4: cnt = 8'($urandom_range(2, 16));
      default: cnt = 8'($urandom);
    endcase
    count = {8'($urandom), cnt};
    case ($urandom_range(0, 5))
      0: xg = 16'h7FFF;
      1: xg = 16'h8000;
      2: xg = '0;
      default: xg = 16'($urandom_range(0, 255) - 128);
    endcase
    case ($urandom_range(0, 5))
      0: yg = 16'h7FFF;
      1: yg = 16'h8000;
      2: yg = '0;
      default: yg = 16'($urandom_range(0, 255) - 128);
    endcase
    apply_settings(speed, count, xg, yg, pick15(1024), pick15(1024), pick15(64), pick15(64));
    repeat (n_items) send_item(random_item());
    finish_phase();
  endtask

  initial begin
    int sent;
    int len;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single frame, no gravity; position wraps past the top
    send_item(tick_item());
    send_item(load_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
    send_item(tick_item());
    send_item(tick_item());
    finish_phase();

    // no frame wrap, frame minus carry wraps, gravity overflows
    apply_settings(16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, '0, '0, '0, '0);
    send_item(load_item(16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'hFFFF));
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());
    finish_phase();

    // negative carry, widest count, clamp and friction stopping at zero;
    // the mid-run load must keep the phase
    apply_settings(16'h8000, 16'h00FF, 16'h0100, 16'hFF00, 16'h7FFF, 16'h0080,
                   16'h7FFF, 16'h0040);
    send_item(load_item(16'hFFFF, 16'h0001, 16'hFFFF, 16'h7000, 16'h9000));
    send_item(tick_item());
    send_item(load_item(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF));
    send_item(tick_item());
    send_item(tick_item());
    finish_phase();

    // negative frame into a small count, tightest clamp and friction
    apply_settings(16'h0180, 16'h0007, '0, '0, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    send_item(load_item(16'h0000, 16'h0000, 16'hFFFB, 16'h8000, 16'h7FFF));
    send_item(tick_item());
    send_item(tick_item());
    finish_phase();

    sent = 0;
    while (sent < 840) begin
      len     = $urandom_range(30, 90);
      idle_on = ($urandom_range(0, 3) != 0);
      run_random_phase(len);
      sent += len;
    end
    idle_on = 1'b0;
    run_random_phase(60);

    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sprite_motion_animation_step.f =====
design/smas_pkg.sv
design/smas_seq.sv
design/smas_dp.sv
design/sprite_motion_animation_step.sv
tb/tb_sprite_motion_animation_step.sv
